@@ hw/rtl/rmn_pkg.sv @@
package rmn_pkg;

	// field widths fixed by the item format
	localparam int CH_W = 4;
	localparam int OUT_W = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int M_TDATA_W = ((CH_W + OUT_W + 7) / 8) * 8;

	// operation codes (s_tuser)
	localparam logic OP_NORMALIZE = 1'b0;
	localparam logic OP_RESET = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LOW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_HIGH = 1'd1;

	// divider status back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

@@ hw/rtl/rmn_range_file.sv @@
module rmn_range_file #(
	parameter int DEPTH = 16,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic [ADDR_W-1:0]        rd_addr,
	input  logic                     wr_en,
	input  logic [ADDR_W-1:0]        wr_addr,
	input  logic signed [DATA_W-1:0] wr_lo,
	input  logic signed [DATA_W-1:0] wr_hi,
	output logic                     rd_seen,
	output logic signed [DATA_W-1:0] rd_lo,
	output logic signed [DATA_W-1:0] rd_hi
);

	logic [DEPTH-1:0] seen_q;
	logic signed [DATA_W-1:0] lo_mem [DEPTH];
	logic signed [DATA_W-1:0] hi_mem [DEPTH];
	logic rd_seen_q;
	logic signed [DATA_W-1:0] rd_lo_q;
	logic signed [DATA_W-1:0] rd_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			rd_seen_q <= 1'b0;
		end else begin
			rd_seen_q <= seen_q[rd_addr];
			if (clear) begin
				seen_q <= '0;
			end else if (wr_en) begin
				seen_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lo_mem[wr_addr] <= wr_lo;
			hi_mem[wr_addr] <= wr_hi;
		end
		rd_lo_q <= lo_mem[rd_addr];
		rd_hi_q <= hi_mem[rd_addr];
	end

	assign rd_seen = rd_seen_q;
	assign rd_lo = rd_lo_q;
	assign rd_hi = rd_hi_q;

endmodule

@@ hw/rtl/rmn_divider.sv @@
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits QW bits, i.e. the top W dividend bits are below the divisor.
module rmn_divider #(
	parameter int W = 16,
	parameter int QW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [W+QW-1:0]      dividend,
	input  logic [W-1:0]         divisor,
	output logic [QW-1:0]        quotient,
	output rmn_pkg::div_status_t status
);

	localparam int CNT_W = $clog2(QW + 1);

	logic [W-1:0]     rem_q;
	logic [QW-1:0]    low_q;
	logic [W-1:0]     dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       trial;
	logic [W:0]       trial_sub;
	logic             ge;

	assign trial = {rem_q, low_q[QW-1]};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign ge = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[W+QW-1:QW];
			low_q <= dividend[QW-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[W-1:0] : trial[W-1:0];
			low_q <= {low_q[QW-2:0], ge};
		end
	end

	assign quotient = low_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

@@ hw/rtl/running_minmax_normalizer.sv @@
// Per-channel running min/max normalizer. Each sample transfer widens its
// channel's stored minimum and maximum to include the sample and returns
// output_low + (x - min) * (output_high - output_low) / (max - min), truncated
// toward zero (output_low when min equals max); a reset transfer (tuser = 1)
// clears all channels and returns nothing, and a channel at or above CHANNELS
// is dropped. A sample goes from acceptance to the output register via
// range read, bound update, one multiply, 16 steps of the shared restoring
// divider (one quotient bit per cycle; skipped when min equals max) and
// result. A reset or dropped transfer leaves the input ready. The result waits
// in an output register, so the next sample is taken while it is unread.
module running_minmax_normalizer #(
	parameter int CHANNELS = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [rmn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rmn_pkg::CFG_W-1:0]      cfg_data,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [((rmn_pkg::CH_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata, // channel, sample
	input  logic                           s_tuser,  // operation
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rmn_pkg::M_TDATA_W-1:0]  m_tdata   // out_channel, normalized
);

	localparam int CH_W = rmn_pkg::CH_W;
	localparam int OUT_W = rmn_pkg::OUT_W;
	localparam int LIVE_CH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
	localparam int ADDR_W = (LIVE_CH > 1) ? $clog2(LIVE_CH) : 1;
	localparam logic [8:0] CH_LIMIT = 9'(CHANNELS);
	localparam int PAD_W = rmn_pkg::M_TDATA_W - CH_W - OUT_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic signed [OUT_W-1:0] out_low_q;
	logic signed [OUT_W-1:0] out_high_q;
	logic [CH_W-1:0] ch_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [SAMPLE_BITS-1:0] dx_q;
	logic [SAMPLE_BITS-1:0] span_q;
	logic [OUT_W-1:0] adiff_q;
	logic neg_q;
	logic zero_q;
	logic m_tvalid_q;
	logic [rmn_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic [CH_W-1:0] in_ch;
	logic signed [SAMPLE_BITS-1:0] in_x;
	logic in_xfer;
	logic ch_ok;
	logic rd_seen;
	logic signed [SAMPLE_BITS-1:0] rd_lo;
	logic signed [SAMPLE_BITS-1:0] rd_hi;
	logic signed [SAMPLE_BITS-1:0] lo_new;
	logic signed [SAMPLE_BITS-1:0] hi_new;
	logic signed [SAMPLE_BITS:0] dx_full;
	logic signed [SAMPLE_BITS:0] span_full;
	logic signed [OUT_W:0] diff_full;
	logic [OUT_W:0] adiff_full;
	logic [SAMPLE_BITS+OUT_W-1:0] product;
	logic div_start;
	logic [OUT_W-1:0] quotient;
	rmn_pkg::div_status_t div_st;
	logic [OUT_W-1:0] qmag;
	logic signed [OUT_W:0] res_full;
	logic out_free;

	assign in_ch = s_tdata[CH_W-1:0];
	assign in_x = s_tdata[CH_W +: SAMPLE_BITS];
	assign s_tready = (state_q == S_IDLE);
	assign in_xfer = s_tvalid && s_tready;
	assign ch_ok = {5'd0, in_ch} < CH_LIMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_low_q <= '0;
			out_high_q <= 16'sd1;
		end else if (cfg_we) begin
			if (cfg_index == rmn_pkg::CFG_OUTPUT_LOW) begin
				out_low_q <= cfg_data;
			end else if (cfg_index == rmn_pkg::CFG_OUTPUT_HIGH) begin
				out_high_q <= cfg_data;
			end
		end
	end

	rmn_range_file #(
		.DEPTH  (LIVE_CH),
		.ADDR_W (ADDR_W),
		.DATA_W (SAMPLE_BITS)
	) u_range (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (in_xfer && (s_tuser == rmn_pkg::OP_RESET)),
		.rd_addr (ADDR_W'(in_ch)),
		.wr_en   (state_q == S_UPD),
		.wr_addr (ADDR_W'(ch_q)),
		.wr_lo   (lo_new),
		.wr_hi   (hi_new),
		.rd_seen (rd_seen),
		.rd_lo   (rd_lo),
		.rd_hi   (rd_hi)
	);

	// bound update; first sample of a channel sets both bounds
	always_comb begin
		lo_new = x_q;
		hi_new = x_q;
		if (rd_seen) begin
			lo_new = (x_q < rd_lo) ? x_q : rd_lo;
			hi_new = (x_q > rd_hi) ? x_q : rd_hi;
		end
	end

	assign dx_full = {x_q[SAMPLE_BITS-1], x_q} - {lo_new[SAMPLE_BITS-1], lo_new};
	assign span_full = {hi_new[SAMPLE_BITS-1], hi_new} - {lo_new[SAMPLE_BITS-1], lo_new};
	assign diff_full = {out_high_q[OUT_W-1], out_high_q} - {out_low_q[OUT_W-1], out_low_q};
	assign adiff_full = diff_full[OUT_W] ? (~diff_full + 1'b1) : diff_full;

	// magnitudes only; sign applied after the divide gives truncation toward zero
	assign product = {{OUT_W{1'b0}}, dx_q} * {{SAMPLE_BITS{1'b0}}, adiff_q};
	assign div_start = (state_q == S_MUL) && !zero_q;

	rmn_divider #(
		.W  (SAMPLE_BITS),
		.QW (OUT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (span_q),
		.quotient (quotient),
		.status   (div_st)
	);

	assign qmag = zero_q ? '0 : quotient;
	assign res_full = {out_low_q[OUT_W-1], out_low_q}
		+ (neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag}));
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && (s_tuser == rmn_pkg::OP_NORMALIZE) && ch_ok) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= zero_q ? S_OUT : S_DIV;
				end
				S_DIV: begin
					if (div_st.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_q <= in_ch;
			x_q <= in_x;
		end
		if (state_q == S_UPD) begin
			dx_q <= dx_full[SAMPLE_BITS-1:0];
			span_q <= span_full[SAMPLE_BITS-1:0];
			zero_q <= (span_full == '0);
			adiff_q <= adiff_full[OUT_W-1:0];
			neg_q <= diff_full[OUT_W];
		end
		if ((state_q == S_OUT) && out_free) begin
			m_tdata_q <= {{PAD_W{1'b0}}, res_full[OUT_W-1:0], ch_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> !s_tready)
		else $error("input ready while divider busy");

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_OUT))
		else $error("output valid raised outside the result state");

	a_reset_item_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (s_tuser == rmn_pkg::OP_RESET)) |=> (state_q == S_IDLE))
		else $error("reset transfer started a computation");

endmodule
